// File: hdl/u1ls_pkg.sv
`default_nettype none

package u1ls_pkg;

  // field widths
  localparam int LINK_W    = 16;
  localparam int OUT_W     = 18;
  localparam int SITE_W    = 6;
  localparam int EXT_W     = 7;
  localparam int COORD_W   = EXT_W;
  localparam int CFG_IDX_W = 1;
  localparam int NUM_LINKS = 6;

  // saturation bounds, signed q3.14
  localparam logic signed [OUT_W-1:0] OUT_MAX_C = 18'sh1FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN_C = 18'sh20000;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_EXTENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_T_EXTENT = 1'b1;

  // link directions
  localparam logic DIR_X = 1'b0;
  localparam logic DIR_T = 1'b1;

  // which link address the datapath presents to the store
  typedef enum logic [2:0] {
    SEL_L0,
    SEL_L1,
    SEL_L2,
    SEL_L3,
    SEL_L4,
    SEL_L5,
    SEL_WR
  } addr_sel_e;

  // complex multiply steps: two per staple term
  typedef enum logic [1:0] {
    STEP_UP1,
    STEP_UP2,
    STEP_DN1,
    STEP_DN2
  } mul_step_e;

  typedef struct packed {
    logic      load;
    logic      mod_step;
    logic      neigh;
    logic      mem_we;
    logic      mem_re;
    addr_sel_e addr_sel;
    logic      mul_en;
    mul_step_e mul_step;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic op_query;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hdl/u1ls_ram.sv
`default_nettype none

module u1ls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/u1ls_dp.sv
`default_nettype none

module u1ls_dp #(
  parameter int MAX_X     = 64,
  parameter int MAX_T     = 64,
  parameter int FRAC_BITS = 14
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [u1ls_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [u1ls_pkg::EXT_W-1:0]              cfg_data_i,
  input  wire logic                                    operation_i,
  input  wire logic [u1ls_pkg::SITE_W-1:0]             site_x_i,
  input  wire logic [u1ls_pkg::SITE_W-1:0]             site_t_i,
  input  wire logic                                    direction_i,
  input  wire logic signed [u1ls_pkg::LINK_W-1:0]      link_real_i,
  input  wire logic signed [u1ls_pkg::LINK_W-1:0]      link_imag_i,
  input  wire u1ls_pkg::dp_cmd_t                       cmd_i,
  output u1ls_pkg::dp_sts_t                            sts_o,
  output logic signed [u1ls_pkg::OUT_W-1:0]            staple_real_o,
  output logic signed [u1ls_pkg::OUT_W-1:0]            staple_imag_o
);

  import u1ls_pkg::*;

  localparam int Depth = MAX_X * MAX_T * 2;
  localparam int AddrW = $clog2(Depth);
  localparam int IdxW  = AddrW - 1;
  localparam int WordW = 2 * LINK_W;
  localparam int OpW   = LINK_W + 1;
  localparam int P1W   = 2 * LINK_W + 1 - FRAC_BITS;
  localparam int MulAW = (P1W > OpW) ? P1W : OpW;
  localparam int ProdW = MulAW + OpW;
  localparam int RawW  = ProdW + 1;
  localparam int SumW  = RawW + 1;

  localparam logic [EXT_W-1:0] MaxXC = (MAX_X > 127) ? 7'd127 : EXT_W'(MAX_X);
  localparam logic [EXT_W-1:0] MaxTC = (MAX_T > 127) ? 7'd127 : EXT_W'(MAX_T);
  localparam logic [EXT_W-1:0] MinExt = 7'd2;

  // configuration
  logic [EXT_W-1:0] x_extent_q, t_extent_q;
  logic [EXT_W-1:0] nx, nt;

  // item registers
  logic                      op_q, dir_q;
  logic [SITE_W-1:0]         sx_sh_q, st_sh_q;
  logic [COORD_W-1:0]        x_q, t_q, xp_q, xm_q, tp_q, tm_q;
  logic [COORD_W-1:0]        xp_d, xm_d, tp_d, tm_d;
  logic signed [LINK_W-1:0]  link_re_q, link_im_q;

  // store access
  logic [COORD_W-1:0] ax, at;
  logic               ad;
  logic [31:0]        lin;
  logic [AddrW-1:0]   addr;
  logic [WordW-1:0]   rdata;
  logic               rd_pend_q;
  logic [2:0]         rd_slot_q;
  logic [WordW-1:0]   link_q [NUM_LINKS];

  // complex multiplier
  logic signed [MulAW-1:0] a_re, a_im, p1_re_q, p1_im_q;
  logic signed [OpW-1:0]   b_re, b_im;
  logic signed [ProdW-1:0] pr_rr_q, pr_ii_q, pr_ri_q, pr_ir_q;
  logic                    mul_vld_q;
  mul_step_e               mul_step_q;
  logic signed [RawW-1:0]  raw_re, raw_im, sh_re, sh_im;
  logic signed [RawW-1:0]  up_re_q, up_im_q, dn_re_q, dn_im_q;
  logic signed [SumW-1:0]  sum_re, sum_im;
  logic signed [OUT_W-1:0] sat_re, sat_im;

  function automatic logic [COORD_W-1:0] mod_step_f(input logic [COORD_W-1:0] r,
                                                    input logic b,
                                                    input logic [EXT_W-1:0] n);
    logic [COORD_W:0] tmp;
    tmp = {r, b};
    if (tmp >= {1'b0, n}) begin
      tmp = tmp - {1'b0, n};
    end
    return tmp[COORD_W-1:0];
  endfunction

  function automatic logic signed [OpW-1:0] re_of(input logic [WordW-1:0] w);
    logic signed [LINK_W-1:0] v;
    v = w[WordW-1:LINK_W];
    return OpW'(v);
  endfunction

  function automatic logic signed [OpW-1:0] im_of(input logic [WordW-1:0] w);
    logic signed [LINK_W-1:0] v;
    v = w[LINK_W-1:0];
    return OpW'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_extent_q <= 7'd64;
      t_extent_q <= 7'd64;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_X_EXTENT) begin
        x_extent_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_T_EXTENT) begin
        t_extent_q <= cfg_data_i;
      end
    end
  end

  // active extents, clamped to the lattice
  assign nx = (x_extent_q < MinExt) ? MinExt : (x_extent_q > MaxXC) ? MaxXC : x_extent_q;
  assign nt = (t_extent_q < MinExt) ? MinExt : (t_extent_q > MaxTC) ? MaxTC : t_extent_q;

  // periodic neighbours
  always_comb begin
    logic [COORD_W:0] x_inc, t_inc;
    x_inc = {1'b0, x_q} + 1'b1;
    t_inc = {1'b0, t_q} + 1'b1;
    xp_d  = (x_inc == {1'b0, nx}) ? '0 : x_inc[COORD_W-1:0];
    tp_d  = (t_inc == {1'b0, nt}) ? '0 : t_inc[COORD_W-1:0];
    xm_d  = (x_q == '0) ? nx - 1'b1 : x_q - 1'b1;
    tm_d  = (t_q == '0) ? nt - 1'b1 : t_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= operation_i;
      dir_q     <= direction_i;
      sx_sh_q   <= site_x_i;
      st_sh_q   <= site_t_i;
      x_q       <= '0;
      t_q       <= '0;
      link_re_q <= link_real_i;
      link_im_q <= link_imag_i;
    end
    // remainder by the extent, one site bit a cycle
    if (cmd_i.mod_step) begin
      x_q     <= mod_step_f(x_q, sx_sh_q[SITE_W-1], nx);
      t_q     <= mod_step_f(t_q, st_sh_q[SITE_W-1], nt);
      sx_sh_q <= sx_sh_q << 1;
      st_sh_q <= st_sh_q << 1;
    end
    if (cmd_i.neigh) begin
      xp_q <= xp_d;
      xm_q <= xm_d;
      tp_q <= tp_d;
      tm_q <= tm_d;
    end
  end

  assign sts_o.op_query = (op_q == OP_QUERY);

  // link coordinates for each read of a query
  always_comb begin
    ax = x_q;
    at = t_q;
    ad = dir_q;
    if (dir_q == DIR_X) begin
      case (cmd_i.addr_sel)
        SEL_L0:  begin ax = x_q;  at = t_q;  ad = DIR_T; end
        SEL_L1:  begin ax = x_q;  at = tp_q; ad = DIR_X; end
        SEL_L2:  begin ax = xp_q; at = t_q;  ad = DIR_T; end
        SEL_L3:  begin ax = x_q;  at = tm_q; ad = DIR_T; end
        SEL_L4:  begin ax = x_q;  at = tm_q; ad = DIR_X; end
        SEL_L5:  begin ax = xp_q; at = tm_q; ad = DIR_T; end
        default: begin ax = x_q;  at = t_q;  ad = dir_q; end
      endcase
    end else begin
      case (cmd_i.addr_sel)
        SEL_L0:  begin ax = x_q;  at = t_q;  ad = DIR_X; end
        SEL_L1:  begin ax = xp_q; at = t_q;  ad = DIR_T; end
        SEL_L2:  begin ax = x_q;  at = tp_q; ad = DIR_X; end
        SEL_L3:  begin ax = xm_q; at = t_q;  ad = DIR_X; end
        SEL_L4:  begin ax = xm_q; at = t_q;  ad = DIR_T; end
        SEL_L5:  begin ax = xm_q; at = tp_q; ad = DIR_X; end
        default: begin ax = x_q;  at = t_q;  ad = dir_q; end
      endcase
    end
  end

  assign lin  = 32'(ax) * 32'(MAX_T) + 32'(at);
  assign addr = {lin[IdxW-1:0], ad};

  u1ls_ram #(
    .WIDTH(WordW),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mem_we),
    .waddr_i(addr),
    .wdata_i({link_re_q, link_im_q}),
    .re_i   (cmd_i.mem_re),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.mem_re;
      mul_vld_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q  <= 3'(cmd_i.addr_sel);
    mul_step_q <= cmd_i.mul_step;
    if (rd_pend_q) begin
      link_q[rd_slot_q] <= rdata;
    end
  end

  // operand selection; the third factor of the upper term and the first of the
  // lower term are conjugated
  always_comb begin
    a_re = MulAW'(re_of(link_q[0]));
    a_im = MulAW'(im_of(link_q[0]));
    b_re = re_of(link_q[1]);
    b_im = im_of(link_q[1]);
    case (cmd_i.mul_step)
      STEP_UP1: begin
        a_re = MulAW'(re_of(link_q[0]));
        a_im = MulAW'(im_of(link_q[0]));
        b_re = re_of(link_q[1]);
        b_im = im_of(link_q[1]);
      end
      STEP_UP2: begin
        a_re = p1_re_q;
        a_im = p1_im_q;
        b_re = re_of(link_q[2]);
        b_im = -im_of(link_q[2]);
      end
      STEP_DN1: begin
        a_re = MulAW'(re_of(link_q[3]));
        a_im = MulAW'(-im_of(link_q[3]));
        b_re = re_of(link_q[4]);
        b_im = im_of(link_q[4]);
      end
      STEP_DN2: begin
        a_re = p1_re_q;
        a_im = p1_im_q;
        b_re = re_of(link_q[5]);
        b_im = im_of(link_q[5]);
      end
      default: begin
        a_re = p1_re_q;
        a_im = p1_im_q;
      end
    endcase
  end

  // first stage: four real products
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      pr_rr_q <= ProdW'(a_re) * ProdW'(b_re);
      pr_ii_q <= ProdW'(a_im) * ProdW'(b_im);
      pr_ri_q <= ProdW'(a_re) * ProdW'(b_im);
      pr_ir_q <= ProdW'(a_im) * ProdW'(b_re);
    end
  end

  // second stage: combine and floor
  assign raw_re = RawW'(pr_rr_q) - RawW'(pr_ii_q);
  assign raw_im = RawW'(pr_ri_q) + RawW'(pr_ir_q);
  assign sh_re  = raw_re >>> FRAC_BITS;
  assign sh_im  = raw_im >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (mul_vld_q) begin
      case (mul_step_q)
        STEP_UP1, STEP_DN1: begin
          p1_re_q <= sh_re[MulAW-1:0];
          p1_im_q <= sh_im[MulAW-1:0];
        end
        STEP_UP2: begin
          up_re_q <= sh_re;
          up_im_q <= sh_im;
        end
        STEP_DN2: begin
          dn_re_q <= sh_re;
          dn_im_q <= sh_im;
        end
        default: begin
          p1_re_q <= sh_re[MulAW-1:0];
          p1_im_q <= sh_im[MulAW-1:0];
        end
      endcase
    end
  end

  assign sum_re = SumW'(up_re_q) + SumW'(dn_re_q);
  assign sum_im = SumW'(up_im_q) + SumW'(dn_im_q);

  always_comb begin
    if (sum_re > SumW'(OUT_MAX_C)) begin
      sat_re = OUT_MAX_C;
    end else if (sum_re < SumW'(OUT_MIN_C)) begin
      sat_re = OUT_MIN_C;
    end else begin
      sat_re = sum_re[OUT_W-1:0];
    end
    if (sum_im > SumW'(OUT_MAX_C)) begin
      sat_im = OUT_MAX_C;
    end else if (sum_im < SumW'(OUT_MIN_C)) begin
      sat_im = OUT_MIN_C;
    end else begin
      sat_im = sum_im[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      staple_real_o <= sat_re;
      staple_imag_o <= sat_im;
    end
  end

  a_mul_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_vld_q |-> !cmd_i.mul_en)
    else $error("multiplier issued before previous step settled");

  a_read_before_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !cmd_i.mul_en)
    else $error("multiply issued while a link read is outstanding");

  a_extent_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nx >= MinExt && nx <= MaxXC && nt >= MinExt && nt <= MaxTC)
    else $error("active extent out of range");

endmodule

`default_nettype wire

// File: hdl/u1ls_ctrl.sv
`default_nettype none

module u1ls_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output u1ls_pkg::dp_cmd_t        cmd_o,
  input  wire u1ls_pkg::dp_sts_t   sts_i
);

  import u1ls_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_NEIGH,
    ST_WRITE,
    ST_READ,
    ST_MUL,
    ST_WAIT,
    ST_SUM
  } state_e;

  state_e    state_q;
  logic [2:0] cnt_q;
  mul_step_e step_q;
  logic      out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      step_q      <= STEP_UP1;
      out_valid_q <= 1'b0;
    end else begin
      // the summing state refills the output register itself
      if (out_valid_q && out_ready_i && state_q != ST_SUM) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MOD;
            cnt_q   <= '0;
          end
        end
        ST_MOD: begin
          if (cnt_q == 3'(SITE_W - 1)) begin
            state_q <= ST_NEIGH;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_NEIGH: begin
          cnt_q   <= '0;
          state_q <= sts_i.op_query ? ST_READ : ST_WRITE;
        end
        ST_WRITE: begin
          state_q <= ST_IDLE;
        end
        ST_READ: begin
          if (cnt_q == 3'(NUM_LINKS)) begin
            state_q <= ST_MUL;
            step_q  <= STEP_UP1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MUL: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (step_q == STEP_DN2) begin
            state_q <= ST_SUM;
          end else begin
            step_q  <= mul_step_e'(step_q + 1'b1);
            state_q <= ST_MUL;
          end
        end
        ST_SUM: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = SEL_WR;
    cmd_o.mul_step = step_q;
    case (state_q)
      ST_IDLE:  cmd_o.load     = in_valid_i;
      ST_MOD:   cmd_o.mod_step = 1'b1;
      ST_NEIGH: cmd_o.neigh    = 1'b1;
      ST_WRITE: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = SEL_WR;
      end
      ST_READ: begin
        if (cnt_q < 3'(NUM_LINKS)) begin
          cmd_o.mem_re   = 1'b1;
          cmd_o.addr_sel = addr_sel_e'(cnt_q);
        end
      end
      ST_MUL:   cmd_o.mul_en   = 1'b1;
      ST_SUM:   cmd_o.out_load = !out_valid_q || out_ready_i;
      default:  cmd_o.load     = 1'b0;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_MOD)
    else $error("accepted word did not start coordinate reduction");

  a_result_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_SUM)
    else $error("result raised outside the summing state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten while a result waits");

endmodule

`default_nettype wire

// File: hdl/u1_lattice_staple.sv
// u1 gauge staple engine on a periodic two-dimensional lattice
//
// input channel (in_valid_i / in_ready_o): one word per item. operation_i low
// writes the link (link_real_i, link_imag_i, signed q1.14) at site
// (site_x_i, site_t_i) and direction_i; operation_i high asks for the staple
// sum of that link. coordinates are reduced modulo the active extents.
// output channel (out_valid_o / out_ready_i): one word per query carrying
// staple_real_o / staple_imag_o, signed q3.14, saturated. writes give nothing.
// config port: cfg_we_i with cfg_index_i 0 sets x_extent, 1 sets t_extent;
// written only while the block is idle (the user's duty, not enforced).
// sequencing: the block accepts no new item while one is in flight; the item
// time is set by the bit-serial coordinate reduction, the single read port of
// the link store (six reads) and one shared two-stage complex multiplier (four
// products, each issued only after the previous one has settled).
// a finished result waits in the output register; the next item is accepted
// meanwhile and only a second query stalls, at its final summing step, until
// the receiver takes the waiting word.
// reset: extents return to 64, control clears; the link store is not cleared
// and a link must be written before any query reads it.

`default_nettype none

module u1_lattice_staple #(
  parameter int MAX_X     = 64,
  parameter int MAX_T     = 64,
  parameter int FRAC_BITS = 14
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration writes
  input  wire logic                                 cfg_we_i,
  input  wire logic [u1ls_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [u1ls_pkg::EXT_W-1:0]           cfg_data_i,
  // item channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 operation_i,
  input  wire logic [u1ls_pkg::SITE_W-1:0]          site_x_i,
  input  wire logic [u1ls_pkg::SITE_W-1:0]          site_t_i,
  input  wire logic                                 direction_i,
  input  wire logic signed [u1ls_pkg::LINK_W-1:0]   link_real_i,
  input  wire logic signed [u1ls_pkg::LINK_W-1:0]   link_imag_i,
  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [u1ls_pkg::OUT_W-1:0]         staple_real_o,
  output logic signed [u1ls_pkg::OUT_W-1:0]         staple_imag_o
);

  import u1ls_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: reduction, neighbour setup, six link reads, four multiplies
  u1ls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // datapath: extents, coordinate unit, link store, complex multiplier, output
  u1ls_dp #(
    .MAX_X    (MAX_X),
    .MAX_T    (MAX_T),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .operation_i  (operation_i),
    .site_x_i     (site_x_i),
    .site_t_i     (site_t_i),
    .direction_i  (direction_i),
    .link_real_i  (link_real_i),
    .link_imag_i  (link_imag_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .staple_real_o(staple_real_o),
    .staple_imag_o(staple_imag_o)
  );

endmodule

`default_nettype wire
